// File: src/probe_tlv_parse_window_check_core_macros.svh
// Assertion macros shared by the probe TLV parser RTL.
`ifndef PROBE_TLV_PARSE_WINDOW_CHECK_CORE_MACROS_SVH
`define PROBE_TLV_PARSE_WINDOW_CHECK_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define PTLV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ptlv assertion failed");

// Next-cycle implication, sampled on aclk, off while reset is held.
`define PTLV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ptlv assertion failed");

`endif

// File: src/ptlv_pkg.sv
// Types, constants and codes for the probe TLV parser.
package ptlv_pkg;

    localparam int unsigned PARAM_VALUE_BYTES = 12;
    localparam int unsigned TIME_BYTES        = 8;
    localparam int unsigned MSG_HDR_BYTES     = 2;
    localparam int unsigned TLV_HDR_BYTES     = 4;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MSG_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TLV_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd2;

    typedef enum logic [2:0] {
        PH_MSG,
        PH_HDR,
        PH_SKIP,
        PH_VAL,
        PH_TRAIL,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BADMSG = 3'd1,
        ST_ABSENT = 3'd2,
        ST_LEN    = 3'd3,
        ST_WINDOW = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] req_msg_type;
        logic [14:0] wanted_tlv_type;
        logic [31:0] window_seconds;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] probe_time;
        logic [31:0] probe_flags;
    } result_t;

endpackage

// File: src/ptlv_parser.sv
// Byte-wise TLV parser state, field extraction and window check.
module ptlv_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  ptlv_pkg::cfg_t      cfg,
    input  logic                advance,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [63:0]         now_secs,
    output ptlv_pkg::result_t   result
);

    ptlv_pkg::phase_t  phase_reg, phase_next;
    ptlv_pkg::status_t sticky_reg, sticky_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [23:0]       hdr_reg, hdr_next;
    logic [15:0]       skip_reg, skip_next;
    logic [63:0]       time_reg, time_next;
    logic [31:0]       flags_reg, flags_next;

    logic [31:0]       full_hdr;
    logic [3:0]        cnt_inc;
    logic [15:0]       skip_dec;
    logic [63:0]       gap;
    logic              in_window;
    ptlv_pkg::status_t status;

    assign full_hdr = {hdr_reg, data_byte};
    assign cnt_inc  = cnt_reg + 4'd1;
    assign skip_dec = skip_reg - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ptlv_pkg::PH_MSG;
        end else if (advance) begin
            phase_reg <= last_byte ? ptlv_pkg::PH_MSG : phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sticky_reg <= ptlv_pkg::ST_OK;
            cnt_reg    <= 4'd0;
            skip_reg   <= 16'd0;
        end else if (advance) begin
            if (last_byte) begin
                sticky_reg <= ptlv_pkg::ST_OK;
                cnt_reg    <= 4'd0;
                skip_reg   <= 16'd0;
            end else begin
                sticky_reg <= sticky_next;
                cnt_reg    <= cnt_next;
                skip_reg   <= skip_next;
            end
        end
    end

    // shift registers are fully refilled before they are read
    always_ff @(posedge aclk) begin
        if (advance) begin
            hdr_reg   <= hdr_next;
            time_reg  <= time_next;
            flags_reg <= flags_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        sticky_next = sticky_reg;
        cnt_next    = cnt_reg;
        hdr_next    = hdr_reg;
        skip_next   = skip_reg;
        time_next   = time_reg;
        flags_next  = flags_reg;
        unique case (phase_reg)
            ptlv_pkg::PH_MSG: begin
                hdr_next = full_hdr[23:0];
                cnt_next = cnt_inc;
                if (cnt_inc >= 4'(ptlv_pkg::MSG_HDR_BYTES)) begin
                    cnt_next = 4'd0;
                    if (full_hdr[15:0] != cfg.req_msg_type) begin
                        sticky_next = ptlv_pkg::ST_BADMSG;
                        phase_next  = ptlv_pkg::PH_ERR;
                    end else begin
                        phase_next = ptlv_pkg::PH_HDR;
                    end
                end
            end
            ptlv_pkg::PH_HDR: begin
                hdr_next = full_hdr[23:0];
                cnt_next = cnt_inc;
                if (cnt_inc >= 4'(ptlv_pkg::TLV_HDR_BYTES)) begin
                    cnt_next = 4'd0;
                    // top bit of the type field is the optional flag
                    if (full_hdr[30:16] == cfg.wanted_tlv_type) begin
                        if (full_hdr[15:0] < 16'(ptlv_pkg::PARAM_VALUE_BYTES)) begin
                            sticky_next = ptlv_pkg::ST_LEN;
                            phase_next  = ptlv_pkg::PH_ERR;
                        end else begin
                            skip_next  = full_hdr[15:0] - 16'(ptlv_pkg::PARAM_VALUE_BYTES);
                            phase_next = ptlv_pkg::PH_VAL;
                        end
                    end else if (full_hdr[15:0] != 16'd0) begin
                        skip_next  = full_hdr[15:0];
                        phase_next = ptlv_pkg::PH_SKIP;
                    end
                end
            end
            ptlv_pkg::PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    phase_next = ptlv_pkg::PH_HDR;
                end
            end
            ptlv_pkg::PH_VAL: begin
                if (cnt_reg < 4'(ptlv_pkg::TIME_BYTES)) begin
                    time_next = {time_reg[55:0], data_byte};
                end else begin
                    flags_next = {flags_reg[23:0], data_byte};
                end
                cnt_next = cnt_inc;
                if (cnt_inc >= 4'(ptlv_pkg::PARAM_VALUE_BYTES)) begin
                    cnt_next   = 4'd0;
                    phase_next = (skip_reg == 16'd0) ? ptlv_pkg::PH_DONE
                                                     : ptlv_pkg::PH_TRAIL;
                end
            end
            ptlv_pkg::PH_TRAIL: begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    phase_next = ptlv_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    assign gap       = (now_secs > time_next) ? (now_secs - time_next) : (time_next - now_secs);
    assign in_window = (gap[63:32] == 32'd0) && (gap[31:0] <= cfg.window_seconds);

    always_comb begin
        case (phase_next)
            ptlv_pkg::PH_ERR:  status = sticky_next;
            ptlv_pkg::PH_MSG:  status = ptlv_pkg::ST_BADMSG;
            ptlv_pkg::PH_HDR:  status = ptlv_pkg::ST_ABSENT;
            ptlv_pkg::PH_DONE: status = in_window ? ptlv_pkg::ST_OK : ptlv_pkg::ST_WINDOW;
            default:           status = ptlv_pkg::ST_LEN;
        endcase
    end

    assign result.status      = status;
    assign result.probe_time  = (status == ptlv_pkg::ST_OK) ? time_next : 64'd0;
    assign result.probe_flags = (status == ptlv_pkg::ST_OK) ? flags_next : 32'd0;

endmodule

// File: src/probe_tlv_parse_window_check_core.sv
// Top level of the probe TLV parser: stream ports, config registers, result register.
// Takes one payload byte per cycle while s_tready is high, big-endian, and on the word
// marked tlast returns one result word, registered, in the cycle after: status, probe
// timestamp and flags. The parser state and the 64-bit window compare sit between
// the byte input and a single result register. Non-last words are taken even while
// a result waits; a last word waits only while a result is held and m_tready is low.
// The user must write config registers only while the block is idle; no logic checks it.
`include "probe_tlv_parse_window_check_core_macros.svh"

module probe_tlv_parse_window_check_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [ptlv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptlv_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [71:0]                        s_tdata,   // data_byte[7:0], now_secs[71:8]
    input  logic                               s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [103:0]                       m_tdata    // status[2:0], probe_time[66:3],
                                                          // probe_flags[98:67], zero pad
);

    ptlv_pkg::cfg_t    cfg_reg;
    ptlv_pkg::result_t res;
    ptlv_pkg::result_t res_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              s_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ptlv_pkg::CFG_MSG_TYPE: cfg_reg.req_msg_type    <= cfg_wr_data[15:0];
                ptlv_pkg::CFG_TLV_TYPE: cfg_reg.wanted_tlv_type <= cfg_wr_data[14:0];
                ptlv_pkg::CFG_WINDOW:   cfg_reg.window_seconds  <= cfg_wr_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready || !s_tlast;
    assign s_accept = s_tvalid && s_tready;

    ptlv_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .advance   (s_accept),
        .data_byte (s_tdata[7:0]),
        .last_byte (s_tlast),
        .now_secs  (s_tdata[71:8]),
        .result    (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (s_accept && s_tlast) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, res_reg.probe_flags, res_reg.probe_time, res_reg.status};

    `PTLV_ASSERT_NEXT(a_last_gives_result, s_tvalid && s_tready && s_tlast, m_tvalid)
    `PTLV_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= 3'(ptlv_pkg::ST_WINDOW))
    `PTLV_ASSERT_NOW(a_error_clears_fields,
                     m_tvalid && (m_tdata[2:0] != 3'(ptlv_pkg::ST_OK)), m_tdata[98:3] == 96'd0)
    `PTLV_ASSERT_NOW(a_no_overwrite, m_tvalid && !m_tready && s_tvalid && s_tlast, !s_tready)

endmodule
